>>> design/ptw_pkg.sv
// Shared constants, codes and types of the page table walker.
package ptw_pkg;

    localparam int NUM_FRAMES = 64;

    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int IDX_W   = 9;
    localparam int ADDR_W  = FRAME_W + IDX_W;
    localparam int DEPTH   = NUM_FRAMES * (1 << IDX_W);
    localparam int VPN_W   = 45;
    localparam int PPN_W   = 52;
    localparam int ENTRY_W = PPN_W + 1;
    localparam int LVL_W   = 3;
    localparam int ROOT_W  = 6;
    localparam int FFREE_W = 7;
    localparam int FU_W    = $clog2(NUM_FRAMES + 1);
    localparam int NEXT_W  = ((FU_W > FFREE_W) ? FU_W : FFREE_W) + 1;
    localparam int ST_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FFREE_W;
    localparam bit IS_POW2 = ((NUM_FRAMES & (NUM_FRAMES - 1)) == 0);

    localparam logic [LVL_W-1:0] LEAF_LVL = LVL_W'(4);

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_NOMAP = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b1;

    // Micro-operations issued by the sequencer to the datapath.
    typedef enum logic [3:0] {
        A_NONE      = 4'd0,
        A_CLEAR     = 4'd1,
        A_ACCEPT    = 4'd2,
        A_MOD_START = 4'd3,
        A_READ      = 4'd4,
        A_ALLOC     = 4'd5,
        A_DESCEND   = 4'd6,
        A_LOOKUP    = 4'd7,
        A_LEAF_WR   = 4'd8,
        A_NOMAP     = 4'd9,
        A_FULL      = 4'd10,
        A_RESULT    = 4'd11
    } t_act;

    // Datapath status seen by the sequencer's branch conditions.
    typedef struct packed {
        logic clr_more;
        logic in_valid;
        logic mod_busy;
        logic leaf;
        logic entry_valid;
        logic update;
        logic full;
        logic out_blocked;
    } t_flags;

    function automatic logic [IDX_W-1:0] vpn_index(input logic [VPN_W-1:0] vpn,
                                                   input logic [LVL_W-1:0] lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            3'd0:    idx = vpn[44:36];
            3'd1:    idx = vpn[35:27];
            3'd2:    idx = vpn[26:18];
            3'd3:    idx = vpn[17:9];
            3'd4:    idx = vpn[8:0];
            default: idx = '0;
        endcase
        return idx;
    endfunction

endpackage

>>> design/ptw_req_if.sv
// Request channel: command, virtual page number, physical page number, unmap.
interface ptw_req_if import ptw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [VPN_W-1:0] vpn;
    logic [PPN_W-1:0] ppn;
    logic             unmap;

    modport source (output valid, command, vpn, ppn, unmap, input ready);
    modport sink   (input valid, command, vpn, ppn, unmap, output ready);
endinterface

>>> design/ptw_rsp_if.sv
// Response channel: status and translated physical page number.
interface ptw_rsp_if import ptw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [PPN_W-1:0] ppn_out;

    modport source (output valid, status, ppn_out, input ready);
    modport sink   (input valid, status, ppn_out, output ready);
endinterface

>>> design/ptw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

>>> design/ptw_modf.sv
// Reduces a frame number modulo the frame count.
module ptw_modf import ptw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PPN_W-1:0]   i_x,
    output logic               o_busy,
    output logic [FRAME_W-1:0] o_rem
);
    logic [FRAME_W-1:0] r_rem;

    generate
        if (IS_POW2) begin : g_mask
            // Power-of-two frame count: the remainder is the low bits.
            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= i_x[FRAME_W-1:0];
                end
            end
            assign o_busy = 1'b0;
        end else begin : g_serial
            localparam int CNT_W = $clog2(PPN_W + 1);
            logic [PPN_W-1:0]   r_x;
            logic [CNT_W-1:0]   r_cnt;
            logic [FRAME_W:0]   trial;

            // Restoring reduction, one dividend bit per cycle.
            assign trial = {r_rem, r_x[PPN_W-1]};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt <= '0;
                end else if (i_start) begin
                    r_cnt <= CNT_W'(PPN_W);
                end else if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                if (i_start) begin
                    r_x   <= i_x;
                    r_rem <= '0;
                end else if (r_cnt != '0) begin
                    r_x   <= r_x << 1;
                    r_rem <= (trial >= (FRAME_W + 1)'(NUM_FRAMES))
                             ? FRAME_W'(trial - (FRAME_W + 1)'(NUM_FRAMES))
                             : FRAME_W'(trial);
                end
            end
            assign o_busy = (r_cnt != '0);
        end
    endgenerate

    assign o_rem = r_rem;
endmodule

>>> design/ptw_seq.sv
// Microcode sequencer: step counter, control store and branch logic.
module ptw_seq import ptw_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_act   o_act
);
    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [3:0] {
        C_ALWAYS      = 4'd0,
        C_CLR_MORE    = 4'd1,
        C_IN_VALID    = 4'd2,
        C_MOD_BUSY    = 4'd3,
        C_LEAF        = 4'd4,
        C_ENTRY_VALID = 4'd5,
        C_QUERY       = 4'd6,
        C_FULL        = 4'd7,
        C_OUT_BLOCKED = 4'd8
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_upc  on_true;
        t_upc  on_false;
    } t_uword;

    localparam t_upc S_CLEAR   = 5'd0;
    localparam t_upc S_IDLE    = 5'd1;
    localparam t_upc S_MSTART  = 5'd2;
    localparam t_upc S_MWAIT   = 5'd3;
    localparam t_upc S_READ    = 5'd4;
    localparam t_upc S_TLEAF   = 5'd5;
    localparam t_upc S_TVALID  = 5'd6;
    localparam t_upc S_TQUERY  = 5'd7;
    localparam t_upc S_TFULL   = 5'd8;
    localparam t_upc S_ALLOC   = 5'd9;
    localparam t_upc S_DESCEND = 5'd10;
    localparam t_upc S_LEAF    = 5'd11;
    localparam t_upc S_LOOKUP  = 5'd12;
    localparam t_upc S_LEAFWR  = 5'd13;
    localparam t_upc S_NOMAP   = 5'd14;
    localparam t_upc S_FULL    = 5'd15;
    localparam t_upc S_RESULT  = 5'd16;

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uw;
    logic   taken;

    // Control store
    always_comb begin
        unique case (r_pc)
            S_CLEAR:   uw = '{A_CLEAR,     C_CLR_MORE,    S_CLEAR,   S_IDLE};
            S_IDLE:    uw = '{A_ACCEPT,    C_IN_VALID,    S_MSTART,  S_IDLE};
            S_MSTART:  uw = '{A_MOD_START, C_ALWAYS,      S_MWAIT,   S_MWAIT};
            S_MWAIT:   uw = '{A_NONE,      C_MOD_BUSY,    S_MWAIT,   S_READ};
            S_READ:    uw = '{A_READ,      C_ALWAYS,      S_TLEAF,   S_TLEAF};
            S_TLEAF:   uw = '{A_NONE,      C_LEAF,        S_LEAF,    S_TVALID};
            S_TVALID:  uw = '{A_NONE,      C_ENTRY_VALID, S_DESCEND, S_TQUERY};
            S_TQUERY:  uw = '{A_NONE,      C_QUERY,       S_NOMAP,   S_TFULL};
            S_TFULL:   uw = '{A_NONE,      C_FULL,        S_FULL,    S_ALLOC};
            S_ALLOC:   uw = '{A_ALLOC,     C_ALWAYS,      S_MSTART,  S_MSTART};
            S_DESCEND: uw = '{A_DESCEND,   C_ALWAYS,      S_MSTART,  S_MSTART};
            S_LEAF:    uw = '{A_NONE,      C_QUERY,       S_LOOKUP,  S_LEAFWR};
            S_LOOKUP:  uw = '{A_LOOKUP,    C_ALWAYS,      S_RESULT,  S_RESULT};
            S_LEAFWR:  uw = '{A_LEAF_WR,   C_ALWAYS,      S_RESULT,  S_RESULT};
            S_NOMAP:   uw = '{A_NOMAP,     C_ALWAYS,      S_RESULT,  S_RESULT};
            S_FULL:    uw = '{A_FULL,      C_ALWAYS,      S_RESULT,  S_RESULT};
            S_RESULT:  uw = '{A_RESULT,    C_OUT_BLOCKED, S_RESULT,  S_IDLE};
            default:   uw = '{A_NONE,      C_ALWAYS,      S_IDLE,    S_IDLE};
        endcase
    end

    always_comb begin
        unique case (uw.cond)
            C_ALWAYS:      taken = 1'b1;
            C_CLR_MORE:    taken = i_flags.clr_more;
            C_IN_VALID:    taken = i_flags.in_valid;
            C_MOD_BUSY:    taken = i_flags.mod_busy;
            C_LEAF:        taken = i_flags.leaf;
            C_ENTRY_VALID: taken = i_flags.entry_valid;
            C_QUERY:       taken = !i_flags.update;
            C_FULL:        taken = i_flags.full;
            C_OUT_BLOCKED: taken = i_flags.out_blocked;
            default:       taken = 1'b1;
        endcase
        n_pc = taken ? uw.on_true : uw.on_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_act = uw.act;
endmodule

>>> design/page_table_walker.sv
// Top level of the five-level page table walker.
// After reset the walker sweeps the whole frame store to zero, one entry per
// cycle, and takes no request until that is done; configuration writes are
// taken at any time. Each request then runs through a microcoded sequencer
// that reads one table entry per level from a frame store with one write port
// and one read port and registered read data. Each level reduces the frame
// number, reads the entry and tests it, then descends or, for an update that
// finds no table, allocates one; the reduction is a mask of the low bits for a
// power-of-two frame count and a serial restoring reduction otherwise. A query
// stops at the first missing entry. The result sits in an output register, so
// the next request is taken while it waits for the consumer.
module page_table_walker import ptw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ptw_req_if.sink               i_req,
    ptw_rsp_if.source             o_rsp
);
    t_act   act;
    t_flags flags;

    logic [ROOT_W-1:0]  r_root;
    logic [FFREE_W-1:0] r_ffree;
    logic [FU_W-1:0]    r_fused;
    logic [ADDR_W-1:0]  r_clr;

    logic               r_cmd;
    logic [VPN_W-1:0]   r_vpn;
    logic [PPN_W-1:0]   r_ppn;
    logic               r_unmap;
    logic [PPN_W-1:0]   r_src;
    logic [LVL_W-1:0]   r_lvl;
    logic [ST_W-1:0]    r_status;
    logic [PPN_W-1:0]   r_res_ppn;

    logic               r_out_valid;
    logic [ST_W-1:0]    r_out_status;
    logic [PPN_W-1:0]   r_out_ppn;

    logic [FRAME_W-1:0] mod_rem;
    logic               mod_busy;
    logic [ADDR_W-1:0]  walk_addr;
    logic [NEXT_W-1:0]  next_frame;
    logic [ENTRY_W-1:0] entry;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               in_fire;
    logic               out_blocked;
    logic               out_load;

    assign walk_addr   = {mod_rem, vpn_index(r_vpn, r_lvl)};
    assign next_frame  = NEXT_W'(r_ffree) + NEXT_W'(r_fused);
    assign in_fire     = (act == A_ACCEPT) && i_req.valid;
    assign out_blocked = r_out_valid && !o_rsp.ready;
    assign out_load    = (act == A_RESULT) && !out_blocked;

    assign flags.clr_more    = (r_clr != ADDR_W'(DEPTH - 1));
    assign flags.in_valid    = i_req.valid;
    assign flags.mod_busy    = mod_busy;
    assign flags.leaf        = (r_lvl == LEAF_LVL);
    assign flags.entry_valid = entry[0];
    assign flags.update      = r_cmd;
    assign flags.full        = (next_frame >= NEXT_W'(NUM_FRAMES));
    assign flags.out_blocked = out_blocked;

    ptw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_act   (act)
    );

    ptw_modf u_modf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (act == A_MOD_START),
        .i_x     (r_src),
        .o_busy  (mod_busy),
        .o_rem   (mod_rem)
    );

    // Write port: clearing sweep, table allocation or leaf update.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = walk_addr;
        ram_wdata = '0;
        unique case (act)
            A_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            A_ALLOC: begin
                ram_we    = 1'b1;
                ram_wdata = {PPN_W'(next_frame), 1'b1};
            end
            A_LEAF_WR: begin
                ram_we    = 1'b1;
                ram_wdata = r_unmap ? '0 : {r_ppn, 1'b1};
            end
            default: ;
        endcase
    end

    ptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (act == A_READ),
        .i_raddr (walk_addr),
        .o_rdata (entry)
    );

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root  <= '0;
            r_ffree <= FFREE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROOT:       r_root  <= i_cfg_data[ROOT_W-1:0];
                CFG_FIRST_FREE: r_ffree <= i_cfg_data[FFREE_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_fused     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (act == A_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (act == A_ALLOC) begin
                r_fused <= r_fused + FU_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd     <= i_req.command;
            r_vpn     <= i_req.vpn;
            r_ppn     <= i_req.ppn;
            r_unmap   <= i_req.unmap;
            r_src     <= PPN_W'(r_root);
            r_lvl     <= '0;
            r_status  <= ST_OK;
            r_res_ppn <= '0;
        end
        if (act == A_ALLOC) begin
            r_src <= PPN_W'(next_frame);
            r_lvl <= r_lvl + LVL_W'(1);
        end
        if (act == A_DESCEND) begin
            r_src <= entry[ENTRY_W-1:1];
            r_lvl <= r_lvl + LVL_W'(1);
        end
        if (act == A_LOOKUP) begin
            if (entry[0]) begin
                r_res_ppn <= entry[ENTRY_W-1:1];
            end else begin
                r_status <= ST_NOMAP;
            end
        end
        if (act == A_NOMAP) begin
            r_status <= ST_NOMAP;
        end
        if (act == A_FULL) begin
            r_status <= ST_FULL;
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_ppn    <= r_res_ppn;
        end
    end

    assign i_req.ready    = (act == A_ACCEPT);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.ppn_out  = r_out_ppn;
endmodule

>>> design/ptw_checker.sv
// Port-level checks for the page table walker, bound to the top level.
module ptw_checker import ptw_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [ST_W-1:0]  i_out_status,
    input logic [PPN_W-1:0] i_out_ppn
);
    // Store is being cleared right after reset: no request, no result.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("request taken or result shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_status) && $stable(i_out_ppn))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == ST_OK) || (i_out_status == ST_NOMAP)
                        || (i_out_status == ST_FULL))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_OK) |-> (i_out_ppn == '0))
        else $error("failed transaction carries a page number");
endmodule

bind page_table_walker ptw_checker u_ptw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_status (o_rsp.status),
    .i_out_ppn    (o_rsp.ppn_out)
);
